>>> design/awc_pkg.sv
// ----------------------------------------------------------------------------
// awc_pkg: shared definitions for the attention window crop block
// Sizes, field layout of the stream words, register codes and the types
// that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package awc_pkg;

  // Store and window limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 31;
  localparam int PIXEL_BITS = 8;

  localparam int MAX_SIDE = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int SIZE_W   = $clog2(MAX_SIDE + 1);
  localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
  localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;

  // Fixed field widths of the stream items
  localparam int LOAD_W    = 8;
  localparam int PIXIN_W   = 8;
  localparam int WIN_W     = 6;
  localparam int FOC_W     = 17;
  localparam int PIXOUT_W  = 8;
  localparam int FRAC_BITS = 16;

  // Input tdata layout, lowest field first
  localparam int LDX_LSB    = 0;
  localparam int LDY_LSB    = LDX_LSB + LOAD_W;
  localparam int PIXIN_LSB  = LDY_LSB + LOAD_W;
  localparam int WINI_LSB   = PIXIN_LSB + PIXIN_W;
  localparam int WINJ_LSB   = WINI_LSB + WIN_W;
  localparam int FOCX_LSB   = WINJ_LSB + WIN_W;
  localparam int FOCY_LSB   = FOCX_LSB + FOC_W;
  localparam int IN_FIELD_W = FOCY_LSB + FOC_W;
  localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PIXOUT_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_SIZE_FW = 9;
  localparam int CFG_RAD_FW  = 5;

  // Register values after reset
  localparam int RST_WIDTH  = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
  localparam int RST_HEIGHT = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;
  localparam int RST_RADIUS = (15 > MAX_RADIUS) ? MAX_RADIUS : 15;

  // Queue between front and back end
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_RADIUS = 3'd2,
    CFG_SCALE  = 3'd3,
    CFG_MASK   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [RAD_W-1:0]  radius;
    logic              scale;
    logic              mask;
  } cfg_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  zero;
    logic [ADDR_W-1:0]     addr;
    logic [PIXEL_BITS-1:0] data;
  } q_entry_t;

endpackage

`default_nettype wire

>>> design/awc_ram.sv
// ----------------------------------------------------------------------------
// awc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data that holds
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module awc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/awc_fifo.sv
// ----------------------------------------------------------------------------
// awc_fifo: short queue between front and back end
// Holds classified items so that the front keeps taking input while the
// back end waits on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module awc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  awc_pkg::q_entry_t  push_data,
  output logic               full,
  input  logic               pop,
  output awc_pkg::q_entry_t  head,
  output logic               empty
);
  import awc_pkg::*;

  q_entry_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue pushed while full");

  ap_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue popped while empty");

  ap_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue occupancy did not grow on push");
`endif

endmodule

`default_nettype wire

>>> design/awc_front.sv
// ----------------------------------------------------------------------------
// awc_front: input side of the attention window crop
// Takes stream items, scales the focus point if scaling is on, forms the
// source position, checks image bounds, window bounds and circular mask,
// and hands a memory access (write or read with a zero flag) to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module awc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  awc_pkg::cfg_t                   cfg,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [awc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  output logic                            q_push,
  output awc_pkg::q_entry_t               q_data,
  input  logic                            q_full
);
  import awc_pkg::*;

  localparam int PROD_A = SIZE_W + 1 + FOC_W;
  localparam int PROD_B = FOC_W + FRAC_BITS;
  localparam int PROD_W = (PROD_A > PROD_B) ? PROD_A : PROD_B;
  localparam int CEN_W  = PROD_W - FRAC_BITS;
  localparam int SX_W   = CEN_W + 2;
  localparam int DIFF_W = ((WIN_W > RAD_W) ? WIN_W : RAD_W) + 2;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;

  // Unpack the input word
  mode_t                    in_mode;
  logic [LOAD_W-1:0]        ld_x, ld_y;
  logic [PIXIN_W-1:0]       pix_in;
  logic [WIN_W-1:0]         win_i, win_j;
  logic signed [FOC_W-1:0]  foc_x, foc_y;

  assign in_mode = mode_t'(in_tuser);
  assign ld_x    = in_tdata[LDX_LSB +: LOAD_W];
  assign ld_y    = in_tdata[LDY_LSB +: LOAD_W];
  assign pix_in  = in_tdata[PIXIN_LSB +: PIXIN_W];
  assign win_i   = in_tdata[WINI_LSB +: WIN_W];
  assign win_j   = in_tdata[WINJ_LSB +: WIN_W];
  assign foc_x   = $signed(in_tdata[FOCX_LSB +: FOC_W]);
  assign foc_y   = $signed(in_tdata[FOCY_LSB +: FOC_W]);

  // Stage one: focus products, window offsets and their squares
  logic signed [SIZE_W:0]       sz_x, sz_y;
  logic signed [SIZE_W+FOC_W:0] prod_x, prod_y;
  logic signed [PROD_W-1:0]     cen_raw_x, cen_raw_y;
  logic signed [DIFF_W-1:0]     di, dj;
  logic signed [SQ_W-1:0]       sq_i, sq_j;
  logic                         in_win, ld_ok;
  logic [ADDR_W-1:0]            ld_addr;

  assign sz_x   = $signed({1'b0, cfg.width});
  assign sz_y   = $signed({1'b0, cfg.height});
  assign prod_x = sz_x * foc_x;
  assign prod_y = sz_y * foc_y;

  // Integer focus is shifted up so the same truncation returns it unchanged
  assign cen_raw_x = cfg.scale ? PROD_W'(prod_x) : (PROD_W'(foc_x) <<< FRAC_BITS);
  assign cen_raw_y = cfg.scale ? PROD_W'(prod_y) : (PROD_W'(foc_y) <<< FRAC_BITS);

  assign di   = $signed(DIFF_W'(win_i)) - $signed(DIFF_W'(cfg.radius));
  assign dj   = $signed(DIFF_W'(win_j)) - $signed(DIFF_W'(cfg.radius));
  assign sq_i = di * di;
  assign sq_j = dj * dj;

  assign in_win = (DIFF_W'(win_i) <= (DIFF_W'(cfg.radius) << 1)) &&
                  (DIFF_W'(win_j) <= (DIFF_W'(cfg.radius) << 1));

  assign ld_ok   = (32'(ld_x) < MAX_WIDTH) && (32'(ld_y) < MAX_HEIGHT);
  assign ld_addr = ADDR_W'(ADDR_W'(ld_y) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(ld_x);

  logic                     s1_v_r, s1_v_nxt;
  mode_t                    s1_mode_r;
  logic                     s1_ld_ok_r;
  logic [ADDR_W-1:0]        s1_ld_addr_r;
  logic [PIXEL_BITS-1:0]    s1_pix_r;
  logic [WIN_W-1:0]         s1_wi_r, s1_wj_r;
  logic signed [PROD_W-1:0] s1_cx_r, s1_cy_r;
  logic [SQ_W-1:0]          s1_sqi_r, s1_sqj_r;
  logic                     s1_in_win_r;

  logic     s2_v_r, s2_v_nxt;
  q_entry_t s2_entry_r;
  logic     s1_ready, s2_ready, s1_keep, in_xfer;

  assign s2_ready  = !s2_v_r || !q_full;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_tready = s1_ready;
  assign in_xfer   = in_tvalid && s1_ready;

  // Stage two: truncate centre toward zero, form source position and checks
  logic signed [PROD_W-1:0] bias_x, bias_y, tr_x, tr_y;
  logic signed [CEN_W-1:0]  cx, cy;
  logic signed [SX_W-1:0]   sx, sy;
  logic                     ok_x, ok_y, in_circle;
  logic [2*RAD_W-1:0]       rr;
  logic [SQ_W:0]            sq_sum;
  logic [ADDR_W-1:0]        rd_addr;
  q_entry_t                 s2_entry_nxt;

  assign bias_x = s1_cx_r[PROD_W-1] ? PROD_W'(FRAC_MASK) : '0;
  assign bias_y = s1_cy_r[PROD_W-1] ? PROD_W'(FRAC_MASK) : '0;
  assign tr_x   = s1_cx_r + bias_x;
  assign tr_y   = s1_cy_r + bias_y;
  assign cx     = tr_x[PROD_W-1:FRAC_BITS];
  assign cy     = tr_y[PROD_W-1:FRAC_BITS];

  assign sx = $signed(SX_W'(s1_wi_r)) + SX_W'(cx) - $signed(SX_W'(cfg.radius));
  assign sy = $signed(SX_W'(s1_wj_r)) + SX_W'(cy) - $signed(SX_W'(cfg.radius));

  assign ok_x = !sx[SX_W-1] && (sx < $signed(SX_W'(cfg.width)));
  assign ok_y = !sy[SX_W-1] && (sy < $signed(SX_W'(cfg.height)));

  assign rr        = cfg.radius * cfg.radius;
  assign sq_sum    = (SQ_W+1)'(s1_sqi_r) + (SQ_W+1)'(s1_sqj_r);
  assign in_circle = sq_sum < (SQ_W+1)'(rr);

  assign rd_addr = ADDR_W'(ADDR_W'(sy[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)) +
                   ADDR_W'(sx[COL_W-1:0]);

  // Drop loads that fall outside the store
  assign s1_keep = (s1_mode_r == MODE_READ) || s1_ld_ok_r;

  always_comb begin
    s2_entry_nxt.mode = s1_mode_r;
    s2_entry_nxt.data = s1_pix_r;
    s2_entry_nxt.zero = !(s1_in_win_r && ok_x && ok_y && (!cfg.mask || in_circle));
    s2_entry_nxt.addr = (s1_mode_r == MODE_READ) ? rd_addr : s1_ld_addr_r;
  end

  // Stage valids
  assign s1_v_nxt = in_xfer || (s1_v_r && !s2_ready);
  assign s2_v_nxt = (s1_v_r && s2_ready && s1_keep) || (s2_v_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r    <= in_mode;
      s1_ld_ok_r   <= ld_ok;
      s1_ld_addr_r <= ld_addr;
      s1_pix_r     <= PIXEL_BITS'(pix_in);
      s1_wi_r      <= win_i;
      s1_wj_r      <= win_j;
      s1_cx_r      <= cen_raw_x;
      s1_cy_r      <= cen_raw_y;
      s1_sqi_r     <= sq_i;
      s1_sqj_r     <= sq_j;
      s1_in_win_r  <= in_win;
    end
    if (s1_v_r && s2_ready) begin
      s2_entry_r <= s2_entry_nxt;
    end
  end

  assign q_push = s2_v_r && !q_full;
  assign q_data = s2_entry_r;

endmodule

`default_nettype wire

>>> design/awc_back.sv
// ----------------------------------------------------------------------------
// awc_back: memory side of the attention window crop
// Pops queued accesses, writes loaded pixels, reads window pixels from the
// frame store and presents them on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module awc_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  awc_pkg::q_entry_t                head,
  input  logic                             q_empty,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [awc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import awc_pkg::*;

  logic                  r1_v_r, r1_v_nxt;
  logic                  r1_zero_r;
  logic                  we, re;
  logic [PIXEL_BITS-1:0] rdata;
  logic [PIXEL_BITS-1:0] pix;

  // Writes never wait; reads wait for a free result slot
  assign we    = !q_empty && (head.mode == MODE_LOAD);
  assign re    = !q_empty && (head.mode == MODE_READ) && (!r1_v_r || out_tready);
  assign q_pop = we || re;

  awc_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (we),
    .waddr (head.addr),
    .wdata (head.data),
    .re    (re),
    .raddr (head.addr),
    .rdata (rdata)
  );

  // Hold the result until it is taken
  always_comb begin
    r1_v_nxt = r1_v_r;
    if (re) begin
      r1_v_nxt = 1'b1;
    end else if (out_tready) begin
      r1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
    end else begin
      r1_v_r <= r1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      r1_zero_r <= head.zero;
    end
  end

  assign pix        = r1_zero_r ? '0 : rdata;
  assign out_tvalid = r1_v_r;
  assign out_tdata  = OUT_TDATA_W'(PIXOUT_W'(pix));

`ifndef SYNTHESIS
  ap_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    re |-> (!r1_v_r || out_tready))
    else $error("read issued over a pending result");

  ap_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    re |=> out_tvalid)
    else $error("read did not produce a result");
`endif

endmodule

`default_nettype wire

>>> design/attention_window_crop_top.sv
// ----------------------------------------------------------------------------
// attention_window_crop_top: region-of-interest crop with circular mask
// Frame store loaded pixel by pixel; read items return one pixel of a
// square window around a focus point, zero outside image, window or mask.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless out_tready stalls the results, loads
//   and reads mixed freely; the frame store has one write and one read port,
//   and each item uses at most one of them. Path: two front stages, the queue
//   and the registered memory read lie between input transfer and out_tvalid.
// Reset: registers return to width 256, height 256, radius 15, scaling on,
//   mask off; pipeline and queue empty. Frame store content is not cleared.
`default_nettype none

module attention_window_crop_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: load_x, load_y, pixel_in, win_i, win_j, focus_x, focus_y, zero pad
  input  logic [awc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: mode
  input  logic                             in_tuser,
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: pixel_out
  output logic [awc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Configuration writes
  input  logic                             cfg_we,
  input  logic [awc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [awc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import awc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  logic [CFG_SIZE_FW-1:0] size_val;
  logic [CFG_RAD_FW-1:0]  rad_val;
  logic [SIZE_W-1:0]      width_sat, height_sat;
  logic [RAD_W-1:0]       rad_sat;

  // Saturate written values to their legal ranges
  assign size_val = cfg_data[CFG_SIZE_FW-1:0];
  assign rad_val  = cfg_data[CFG_RAD_FW-1:0];

  always_comb begin
    if (size_val == '0) begin
      width_sat  = SIZE_W'(1);
      height_sat = SIZE_W'(1);
    end else begin
      width_sat  = (32'(size_val) > MAX_WIDTH)  ? SIZE_W'(MAX_WIDTH)  : SIZE_W'(size_val);
      height_sat = (32'(size_val) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : SIZE_W'(size_val);
    end
    rad_sat = (32'(rad_val) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(rad_val);
  end

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_WIDTH:  cfg_nxt.width  = width_sat;
        CFG_HEIGHT: cfg_nxt.height = height_sat;
        CFG_RADIUS: cfg_nxt.radius = rad_sat;
        CFG_SCALE:  cfg_nxt.scale  = cfg_data[0];
        CFG_MASK:   cfg_nxt.mask   = cfg_data[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= SIZE_W'(RST_WIDTH);
      cfg_r.height <= SIZE_W'(RST_HEIGHT);
      cfg_r.radius <= RAD_W'(RST_RADIUS);
      cfg_r.scale  <= 1'b1;
      cfg_r.mask   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_data, q_head;

  awc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  awc_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  awc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

>>> sim/attention_window_crop_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attention_window_crop_top_tb: self-checking bench for the window crop block
// Loads pixels into the frame store and reads window pixels under a series
// of register settings. Every accepted read is predicted from a local copy
// of the frame and the registers, and each result transfer is checked in
// order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module attention_window_crop_top_tb;

  import awc_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE       = 8;
  localparam int MAX_REPORTS  = 100;
  localparam int RAND_PHASES  = 14;
  localparam int CHUNK        = 36;
  localparam int CHUNKS       = 3;

  // One stream item: a pixel load or a window read
  typedef struct packed {
    mode_t              mode;
    logic [7:0]         load_x;
    logic [7:0]         load_y;
    logic [7:0]         pixel_in;
    logic [5:0]         win_i;
    logic [5:0]         win_j;
    logic signed [16:0] focus_x;
    logic signed [16:0] focus_y;
  } crop_item_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tuser  = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Register shadow, as the block holds it after saturation
  int cfg_width  = RST_WIDTH;
  int cfg_height = RST_HEIGHT;
  int cfg_radius = RST_RADIUS;
  bit cfg_scale  = 1'b1;
  bit cfg_mask   = 1'b0;

  crop_item_t       pending_items[$];
  crop_item_t       held_item;
  logic [7:0]       expected_pixels[$];
  logic [7:0]       frame_copy[0:MAX_WIDTH*MAX_HEIGHT-1];
  bit               frame_loaded[0:MAX_WIDTH*MAX_HEIGHT-1];

  int send_idle     = 38;
  int recv_idle     = 48;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int errors        = 0;
  int loads_seen    = 0;
  int reads_seen    = 0;
  int lit_pixels    = 0;
  int settings_run  = 1;
  int cycle_count   = 0;

  attention_window_crop_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Window centre on one axis: integer focus, or Q1.16 fraction of the size
  // truncated toward zero
  function automatic int focus_centre(input logic signed [16:0] focus, input int size);
    int     f;
    longint prod;
    f    = focus;
    prod = longint'(size) * longint'(f);
    if (!cfg_scale) return f;
    if (prod < 0) return -int'((-prod) / 65536);
    return int'(prod / 65536);
  endfunction

  // Frame address a read item fetches; returns 0 when the pixel is forced to zero
  function automatic bit window_source(input crop_item_t it, output int addr);
    int cx, cy, sx, sy, di, dj;
    addr = 0;
    if (int'(it.win_i) > 2 * cfg_radius || int'(it.win_j) > 2 * cfg_radius) return 1'b0;
    cx = focus_centre(it.focus_x, cfg_width);
    cy = focus_centre(it.focus_y, cfg_height);
    sx = int'(it.win_i) + cx - cfg_radius;
    sy = int'(it.win_j) + cy - cfg_radius;
    di = int'(it.win_i) - cfg_radius;
    dj = int'(it.win_j) - cfg_radius;
    if (sx < 0 || sx >= cfg_width || sy < 0 || sy >= cfg_height) return 1'b0;
    if (cfg_mask && !(di * di + dj * dj < cfg_radius * cfg_radius)) return 1'b0;
    addr = sy * MAX_WIDTH + sx;
    return 1'b1;
  endfunction

  // Update the frame copy on a load, queue the window pixel on a read
  function automatic void crop_predict(input crop_item_t it);
    int         addr;
    logic [7:0] pix;
    if (it.mode == MODE_LOAD) begin
      frame_copy[int'(it.load_y) * MAX_WIDTH + int'(it.load_x)] = it.pixel_in;
      loads_seen++;
    end else begin
      pix = window_source(it, addr) ? frame_copy[addr] : 8'h00;
      expected_pixels.push_back(pix);
      reads_seen++;
      if (pix != 8'h00) lit_pixels++;
    end
  endfunction

  function automatic crop_item_t load_at(input int x, input int y, input int pix);
    crop_item_t it;
    it          = crop_item_t'({$urandom, $urandom, $urandom});
    it.mode     = MODE_LOAD;
    it.load_x   = 8'(x);
    it.load_y   = 8'(y);
    it.pixel_in = 8'(pix);
    return it;
  endfunction

  function automatic crop_item_t read_at(input int wi, input int wj, input int fx, input int fy);
    crop_item_t it;
    it         = crop_item_t'({$urandom, $urandom, $urandom});
    it.mode    = MODE_READ;
    it.win_i   = 6'(wi);
    it.win_j   = 6'(wj);
    it.focus_x = 17'(fx);
    it.focus_y = 17'(fy);
    return it;
  endfunction

  // Random focus on one axis, mostly landing the window on the image
  function automatic int pick_focus(input int size);
    if ($urandom_range(9) == 0) return int'($urandom_range(131071)) - 65536;
    if (cfg_scale) return int'($urandom_range(65535));
    return int'($urandom_range(size + 2 * cfg_radius + 3)) - cfg_radius - 2;
  endfunction

  // Queue an item; a read that would fetch a never-loaded pixel gets a load first
  task automatic post(input crop_item_t it);
    int addr;
    if (it.mode == MODE_READ && window_source(it, addr) && !frame_loaded[addr]) begin
      post(load_at(addr % MAX_WIDTH, addr / MAX_WIDTH, $urandom_range(255)));
    end
    if (it.mode == MODE_LOAD) begin
      frame_loaded[int'(it.load_y) * MAX_WIDTH + int'(it.load_x)] = 1'b1;
    end
    pending_items.push_back(it);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    int v;
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we   <= 1'b0;
    // Mirror the saturation the block applies
    case (idx)
      CFG_WIDTH: begin
        v = value & 'h1FF;
        cfg_width = (v < 1) ? 1 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
      end
      CFG_HEIGHT: begin
        v = value & 'h1FF;
        cfg_height = (v < 1) ? 1 : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
      end
      CFG_RADIUS: begin
        v = value & 'h1F;
        cfg_radius = (v > MAX_RADIUS) ? MAX_RADIUS : v;
      end
      CFG_SCALE: cfg_scale = value[0];
      CFG_MASK:  cfg_mask  = value[0];
      default: ;
    endcase
  endtask

  task automatic set_all_regs(input int w, input int h, input int r, input int s, input int m);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_SCALE, s);
    write_reg(CFG_MASK, m);
    settings_run++;
  endtask

  // Wait until every queued item is sent and every result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_pixels.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Drive the input stream from the pending queue
  always @(posedge clk) begin : drive_proc
    crop_item_t            nxt_item;
    logic [IN_TDATA_W-1:0] word;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        crop_predict(held_item);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt_item = pending_items.pop_front();
          word = '0;
          word[LDX_LSB   +: LOAD_W]  = nxt_item.load_x;
          word[LDY_LSB   +: LOAD_W]  = nxt_item.load_y;
          word[PIXIN_LSB +: PIXIN_W] = nxt_item.pixel_in;
          word[WINI_LSB  +: WIN_W]   = nxt_item.win_i;
          word[WINJ_LSB  +: WIN_W]   = nxt_item.win_j;
          word[FOCX_LSB  +: FOC_W]   = nxt_item.focus_x;
          word[FOCY_LSB  +: FOC_W]   = nxt_item.focus_y;
          held_item <= nxt_item;
          in_tdata  <= word;
          in_tuser  <= nxt_item.mode;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each result transfer and pace the receiver
  always @(posedge clk) begin : check_proc
    logic [7:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result with none expected: pixel_out=%02h", $time, out_tdata);
        end else begin
          want = expected_pixels.pop_front();
          if (out_tdata !== OUT_TDATA_W'(want)) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: pixel_out mismatch: expected %02h, actual %02h",
                       $time, want, out_tdata);
          end
        end
      end
      // Hold off for a long stretch on request, else stall at random
      if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left    <= HOLD_CYCLES;
        out_tready   <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_pixels.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int p, c, k, wi, wj, span;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: corners, scaled focus extremes, truncation toward zero
    post(load_at(0, 0, 255));
    post(load_at(255, 255, 8'h81));
    post(load_at(0, 255, 0));
    post(load_at(255, 0, 8'h5A));
    post(read_at(15, 15, 0, 0));
    post(read_at(15, 15, 65535, 65535));
    post(read_at(15, 15, 0, 65535));
    post(read_at(15, 15, 65535, 0));
    post(read_at(15, 15, -65536, 0));
    post(read_at(0, 0, 0, 0));
    post(read_at(30, 30, 65535, 65535));
    post(read_at(62, 15, 0, 0));
    post(read_at(15, 62, 0, 0));
    post(read_at(16, 15, -256, 0));
    post(read_at(15, 15, -255, -255));
    wait_drained();

    // Out-of-range register values saturate; zero radius with mask blanks all
    set_all_regs(0, 400, 0, 0, 1);
    post(read_at(0, 0, 0, 0));
    post(read_at(0, 0, 0, 255));
    post(read_at(0, 0, 65535, -65536));
    wait_drained();

    // Largest radius, integer focus, circular mask at its boundary
    set_all_regs(256, 256, 31, 0, 1);
    post(read_at(31, 31, 100, 100));
    post(read_at(0, 31, 100, 100));
    post(read_at(1, 31, 100, 100));
    post(read_at(31, 61, 100, 100));
    post(read_at(62, 62, 100, 100));
    post(read_at(5, 5, 100, 100));
    post(read_at(31, 31, 65535, -65536));
    wait_drained();

    // Random settings, each followed by random loads and reads
    for (p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      case ($urandom_range(5))
        0:       set_all_regs(1, 256, 31, $urandom_range(1), $urandom_range(1));
        1:       set_all_regs(256, $urandom_range(1, 12), $urandom_range(1, 6),
                              $urandom_range(1), $urandom_range(1));
        2, 3:    set_all_regs($urandom_range(2, 12), $urandom_range(2, 12),
                              $urandom_range(0, 6), $urandom_range(1), $urandom_range(1));
        4:       set_all_regs($urandom_range(13, 64), $urandom_range(13, 64),
                              $urandom_range(0, 31), $urandom_range(1), $urandom_range(1));
        default: set_all_regs($urandom_range(1, 256), $urandom_range(1, 256),
                              $urandom_range(0, 31), $urandom_range(1), $urandom_range(1));
      endcase
      @(negedge clk);
      if (p < 5) begin
        send_idle = 38;
        recv_idle = 48;
      end else if (p < 10) begin
        send_idle = 48;
        recv_idle = 38;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      span = 2 * cfg_radius;
      for (c = 0; c < CHUNKS; c++) begin
        for (k = 0; k < CHUNK; k++) begin
          if ($urandom_range(99) < 40) begin
            if ($urandom_range(9) == 0)
              post(load_at($urandom_range(255), $urandom_range(255), $urandom_range(255)));
            else
              post(load_at($urandom_range(cfg_width - 1), $urandom_range(cfg_height - 1),
                           $urandom_range(255)));
          end else begin
            wi = ($urandom_range(9) == 0) ? $urandom_range(62) : $urandom_range(span);
            wj = ($urandom_range(9) == 0) ? $urandom_range(62) : $urandom_range(span);
            post(read_at(wi, wj, pick_focus(cfg_width), pick_focus(cfg_height)));
          end
        end
        // Stall the receiver while the sender keeps offering
        if (p >= 10 && c == 0) begin
          @(negedge clk);
          hold_requests++;
        end
        // Pause the sender until every result is back
        if (c == 0) wait_drained();
      end
    end
    wait_drained();

    $display("covered %0d pixel loads and %0d window reads (%0d nonzero) over %0d settings",
             loads_seen, reads_seen, lit_pixels, settings_run);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d result errors", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
